/* sv/kli_pkg.sv */
package kli_pkg;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_COUNT = 1'd1;

	localparam logic [6:0] KEY_COUNT_RESET       = 7'd1;
	localparam logic [4:0] COMPONENT_COUNT_RESET = 5'd3;

	typedef struct packed {
		logic               req_type;
		logic [5:0]         key_index;
		logic [15:0]        key_time;
		logic [3:0]         component_index;
		logic signed [31:0] component_value;
		logic [15:0]        query_frame;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         out_component;
		logic signed [31:0] out_value;
		logic               exact_key;
		logic               last;
	} out_item_t;

endpackage

/* sv/keyframe_linear_interp.sv */
// Keyframe linear interpolation over a table of animation keys.
// Input channel (in_valid / in_stall, payload in_data) carries two kinds of request:
//   load  - writes one key's time and one of its Q16.16 components.
//   query - looks up a frame and emits one result per component, in component order,
//           on the output channel (out_valid / out_stall, payload out_data), last set
//           on the final component.
// A query runs on one sequencer: a scan of the time table, one read a cycle,
// a setup step, a restoring divider that retires one quotient bit a cycle
// (skipped on an exact hit or when the after key's time is not above the before
// key's), then a read, a multiply on one shared multiplier and an add per component.
// in_stall is high while a query runs. A load is accepted whenever no query is running.
// The last result sits in the output register while the next request is taken.
// When the receiver stalls, the sequencer holds before the output register until
// the waiting result is taken; out_data does not change while stalled.
// Reset clears the sequencer, the output valid and the registers (key_count = 1,
// component_count = 3); key tables are not cleared. The block does not enforce it: the user
// must read them only where written and configure via cfg_we/cfg_index/cfg_data while idle.
module keyframe_linear_interp #(
	parameter int MAX_KEYS       = 64,
	parameter int MAX_COMPONENTS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kli_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kli_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  kli_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output kli_pkg::out_item_t                 out_data
);

	localparam int KW    = $clog2(MAX_KEYS);
	localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int NKW0  = $clog2(MAX_KEYS + 1);
	localparam int NKW   = (NKW0 > 7) ? NKW0 : 7;
	localparam int VDEPTH = MAX_KEYS * (2 ** CW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_RD,
		ST_MUL,
		ST_ADD
	} state_t;

	state_t state_q;

	logic [15:0] time_mem [MAX_KEYS];
	logic [31:0] value_mem [VDEPTH];

	logic [6:0]  key_count_q;
	logic [4:0]  comp_count_q;

	logic [NKW-1:0] nk_q;
	logic [4:0]     nc_q;
	logic [15:0]    frame_q;
	logic [NKW-1:0] issue_q;
	logic           sv_s1;
	logic [KW-1:0]  idx_s1;
	logic [15:0]    t_s1;

	logic           exact_q;
	logic           have_after_q;
	logic [KW-1:0]  hit_q;
	logic [KW-1:0]  bi_q;
	logic [KW-1:0]  ai_q;
	logic [15:0]    tb_q;
	logic [15:0]    ta_q;

	logic [15:0]    rem_q;
	logic [15:0]    den_q;
	logic [15:0]    quo_q;
	logic [3:0]     div_cnt_q;

	logic [CW-1:0]  comp_q;
	logic [31:0]    vb_q;
	logic [31:0]    va_q;
	logic [31:0]    prod_q;

	logic               out_valid_q;
	kli_pkg::out_item_t out_q;

	logic           accept;
	logic           load_ok;
	logic [NKW-1:0] kc_ext;
	logic [NKW-1:0] nk_eff;
	logic [4:0]     nc_eff;
	logic           scan_last;
	logic [16:0]    rem_sh;
	logic           q_bit;
	logic signed [32:0] diff;
	logic signed [49:0] prod;
	logic           comp_last;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign load_ok = ({26'd0, in_data.key_index} < 32'(MAX_KEYS)) &&
		({28'd0, in_data.component_index} < 32'(MAX_COMPONENTS));

	always_comb begin
		kc_ext = NKW'(key_count_q);
		if (kc_ext == '0) begin
			nk_eff = NKW'(1);
		end else if (kc_ext > NKW'(MAX_KEYS)) begin
			nk_eff = NKW'(MAX_KEYS);
		end else begin
			nk_eff = kc_ext;
		end
		if (comp_count_q == 5'd0) begin
			nc_eff = 5'd1;
		end else if (comp_count_q > 5'(MAX_COMPONENTS)) begin
			nc_eff = 5'(MAX_COMPONENTS);
		end else begin
			nc_eff = comp_count_q;
		end
	end

	assign scan_last = (NKW'(idx_s1) == nk_q - NKW'(1));
	assign rem_sh    = {rem_q, 1'b0};
	assign q_bit     = (rem_sh >= {1'b0, den_q});
	assign diff      = $signed({va_q[31], va_q}) - $signed({vb_q[31], vb_q});
	assign prod      = diff * $signed({1'b0, quo_q});
	assign comp_last = (5'(comp_q) == nc_q - 5'd1);

	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == kli_pkg::REQ_LOAD && load_ok) begin
			time_mem[KW'(in_data.key_index)] <= in_data.key_time;
			value_mem[{KW'(in_data.key_index), CW'(in_data.component_index)}] <=
				in_data.component_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= kli_pkg::KEY_COUNT_RESET;
			comp_count_q <= kli_pkg::COMPONENT_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kli_pkg::REG_KEY_COUNT:       key_count_q  <= cfg_data;
				kli_pkg::REG_COMPONENT_COUNT: comp_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sv_s1       <= 1'b0;
		end else begin
			// drop a taken result unless the add stage replaces it
			if (out_valid_q && !out_stall && state_q != ST_ADD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_data.req_type == kli_pkg::REQ_QUERY) begin
						nk_q         <= nk_eff;
						nc_q         <= nc_eff;
						frame_q      <= in_data.query_frame;
						issue_q      <= '0;
						sv_s1        <= 1'b0;
						exact_q      <= 1'b0;
						have_after_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q < nk_q) begin
						t_s1    <= time_mem[issue_q[KW-1:0]];
						idx_s1  <= issue_q[KW-1:0];
						sv_s1   <= 1'b1;
						issue_q <= issue_q + NKW'(1);
					end else begin
						sv_s1 <= 1'b0;
					end
					if (sv_s1) begin
						if (t_s1 == frame_q) begin
							exact_q <= 1'b1;
							hit_q   <= idx_s1;
						end
						// key 0 stands in as the before key until an earlier one shows up
						if (idx_s1 == '0 || t_s1 < frame_q) begin
							bi_q <= idx_s1;
							tb_q <= t_s1;
						end
						// first later key, or the last key when none is later
						if (!have_after_q && (t_s1 > frame_q || scan_last)) begin
							ai_q         <= idx_s1;
							ta_q         <= t_s1;
							have_after_q <= 1'b1;
						end
						if (scan_last) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					comp_q <= '0;
					if (exact_q) begin
						bi_q    <= hit_q;
						quo_q   <= '0;
						state_q <= ST_RD;
					end else if (ta_q <= tb_q) begin
						quo_q   <= '0;
						state_q <= ST_RD;
					end else begin
						rem_q     <= frame_q - tb_q;
						den_q     <= ta_q - tb_q;
						quo_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (q_bit) begin
						rem_q <= 16'(rem_sh - {1'b0, den_q});
					end else begin
						rem_q <= rem_sh[15:0];
					end
					quo_q     <= {quo_q[14:0], q_bit};
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					vb_q    <= value_mem[{bi_q, comp_q}];
					va_q    <= value_mem[{ai_q, comp_q}];
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// low 32 bits of floor(product / 2^16)
					prod_q  <= prod[47:16];
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q         <= 1'b1;
						out_q.out_component <= 4'(comp_q);
						out_q.out_value     <= $signed(vb_q + prod_q);
						out_q.exact_key     <= exact_q;
						out_q.last          <= comp_last;
						if (comp_last) begin
							state_q <= ST_IDLE;
						end else begin
							comp_q  <= comp_q + CW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/kli_checker.sv */
module kli_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [kli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [kli_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input kli_pkg::in_item_t              in_data,
	input logic                           out_valid,
	input logic                           out_stall,
	input kli_pkg::out_item_t             out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// a query occupies the sequencer on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == kli_pkg::REQ_QUERY |=> in_stall)
		else $error("query request not held off the input");

	// a load leaves the input free on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == kli_pkg::REQ_LOAD |=> !in_stall)
		else $error("load request stalled the input");

	// no result is offered while the block is idle and nothing is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid)
		else $error("result appeared without a running query");

endmodule

bind keyframe_linear_interp kli_checker u_kli_checker (.*);
